// File: hw/rtl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared types for the sorted record table
// Record layout, request and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package srt_pkg;

  typedef struct packed {
    logic        [15:0] year;
    logic signed [31:0] flow;
  } rec_t;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_DUP_YEAR  = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;
  localparam logic [1:0] STS_NOT_FOUND = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHUP,
    S_SHDN,
    S_PLACE,
    S_RESP
  } state_t;

endpackage

// File: hw/rtl/sorted_record_table.sv
// Each request runs the scan, then an append, a shift or neither, and then the
// result beat; a new request is taken only once the last result beat is issued.
// The single memory read port reads one entry per cycle in scan and shift.
// Reset: rst_n clears the sequencer, the fill count and the output beat; the
// record memory is not cleared and only entries below the count are used.
// ----------------------------------------------------------------------------
// sorted_record_table: bounded table of (flow, year) records
// Keeps records in ascending signed flow order with year as unique key.
// Each request scans the held entries, then shifts entries up or down by one where needed.
// ----------------------------------------------------------------------------
module sorted_record_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // flow_value[31:0], year_key[47:32]
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // status[1:0], entry_count[6:2], head_valid[7],
                                  // head_flow[39:8], head_year[55:40]
);
  import srt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [CW-1:0] CNT_FULL = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  rec_t mem [TABLE_DEPTH];
  rec_t rd_data_r;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  rec_t          wr_data;

  state_t state_r, state_nxt;

  logic          req_r,       req_nxt;
  rec_t          new_r,       new_nxt;
  logic [CW-1:0] scan_idx_r,  scan_idx_nxt;
  logic          found_r,     found_nxt;
  logic [CW-1:0] found_pos_r, found_pos_nxt;
  logic          pos_found_r, pos_found_nxt;
  logic [CW-1:0] pos_r,       pos_nxt;
  logic [CW-1:0] sh_src_r,    sh_src_nxt;
  logic [CW-1:0] count_r,     count_nxt;
  rec_t          head_r,      head_nxt;
  logic [1:0]    status_r,    status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [55:0]   out_data_r,  out_data_nxt;

  logic          in_acc;
  logic [CW-1:0] data_idx;
  logic          year_hit;
  logic          flow_ge;
  logic          scan_more;
  logic          out_free;
  logic [CW+4:0] cnt_ext;
  rec_t          head_out;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign data_idx  = scan_idx_r - CNT_ONE;
  assign year_hit  = (rd_data_r.year == new_r.year);
  assign flow_ge   = !(rd_data_r.flow < new_r.flow);
  assign scan_more = (scan_idx_r < count_r);
  assign out_free  = !out_valid_r || out_tready;
  assign cnt_ext   = {5'd0, count_r};
  assign head_out  = (count_r != '0) ? head_r : '0;

  // record memory: one read port with registered data, one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (count_r == '0) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (!scan_more) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (req_r == REQ_INSERT) begin
          if (found_r || count_r == CNT_FULL) begin
            state_nxt = S_RESP;
          end else if (pos_r == count_r) begin
            state_nxt = S_PLACE;
          end else begin
            state_nxt = S_SHUP;
          end
        end else begin
          if (!found_r || found_pos_r == count_r - CNT_ONE) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SHDN;
          end
        end
      end
      S_SHUP: begin
        if (sh_src_r == pos_r) begin
          state_nxt = S_PLACE;
        end
      end
      S_SHDN: begin
        if (sh_src_r == count_r - CNT_ONE) begin
          state_nxt = S_RESP;
        end
      end
      S_PLACE: state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = new_r;
    req_nxt       = req_r;
    new_nxt       = new_r;
    scan_idx_nxt  = scan_idx_r;
    found_nxt     = found_r;
    found_pos_nxt = found_pos_r;
    pos_found_nxt = pos_found_r;
    pos_nxt       = pos_r;
    sh_src_nxt    = sh_src_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt       = in_tuser;
          new_nxt.flow  = $signed(in_tdata[31:0]);
          new_nxt.year  = in_tdata[47:32];
          found_nxt     = 1'b0;
          pos_found_nxt = 1'b0;
          pos_nxt       = count_r;
          rd_en         = 1'b1;
          rd_addr       = '0;
          scan_idx_nxt  = CNT_ONE;
        end
      end
      S_SCAN: begin
        if (year_hit && !found_r) begin
          found_nxt     = 1'b1;
          found_pos_nxt = data_idx;
        end
        // insertion point: first entry whose flow is not below the new one
        if (!pos_found_r && flow_ge) begin
          pos_found_nxt = 1'b1;
          pos_nxt       = data_idx;
        end
        if (scan_more) begin
          rd_en        = 1'b1;
          rd_addr      = scan_idx_r[AW-1:0];
          scan_idx_nxt = scan_idx_r + CNT_ONE;
        end
      end
      S_DECIDE: begin
        status_nxt = STS_OK;
        if (req_r == REQ_INSERT) begin
          if (found_r) begin
            status_nxt = STS_DUP_YEAR;
          end else if (count_r == CNT_FULL) begin
            status_nxt = STS_FULL;
          end else if (pos_r != count_r) begin
            // shift up from the top entry down to the insertion point
            rd_en      = 1'b1;
            rd_addr    = data_idx[AW-1:0];
            sh_src_nxt = count_r - CNT_ONE;
          end
        end else begin
          if (!found_r) begin
            status_nxt = STS_NOT_FOUND;
          end else if (found_pos_r == count_r - CNT_ONE) begin
            count_nxt = count_r - CNT_ONE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = found_pos_r[AW-1:0] + AW'(1);
            sh_src_nxt = found_pos_r + CNT_ONE;
          end
        end
      end
      S_SHUP: begin
        wr_en   = 1'b1;
        wr_addr = sh_src_r[AW-1:0] + AW'(1);
        wr_data = rd_data_r;
        if (sh_src_r != pos_r) begin
          rd_en      = 1'b1;
          rd_addr    = sh_src_r[AW-1:0] - AW'(1);
          sh_src_nxt = sh_src_r - CNT_ONE;
        end
      end
      S_SHDN: begin
        wr_en   = 1'b1;
        wr_addr = sh_src_r[AW-1:0] - AW'(1);
        wr_data = rd_data_r;
        if (sh_src_r == CNT_ONE) begin
          head_nxt = rd_data_r;
        end
        if (sh_src_r == count_r - CNT_ONE) begin
          count_nxt = count_r - CNT_ONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = sh_src_r[AW-1:0] + AW'(1);
          sh_src_nxt = sh_src_r + CNT_ONE;
        end
      end
      S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = pos_r[AW-1:0];
        wr_data = new_r;
        if (pos_r == '0) begin
          head_nxt = new_r;
        end
        count_nxt = count_r + CNT_ONE;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {head_out.year, head_out.flow, (count_r != '0),
                           cnt_ext[4:0], status_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    new_r       <= new_nxt;
    scan_idx_r  <= scan_idx_nxt;
    found_r     <= found_nxt;
    found_pos_r <= found_pos_nxt;
    pos_found_r <= pos_found_nxt;
    pos_r       <= pos_nxt;
    sh_src_r    <= sh_src_nxt;
    head_r      <= head_nxt;
    status_r    <= status_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

// File: tb/sorted_record_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_record_table_test: self-checking bench for the sorted record table
// Drives insert and remove requests over the input stream, predicts each
// result beat from a queue-based copy of the table, and checks every field of
// the output stream under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module sorted_record_table_test;
  import srt_pkg::*;

  localparam int DEPTH         = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int QUIET_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 108;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         count;
    logic               head_valid;
    logic signed [31:0] head_flow;
    logic [15:0]        head_year;
  } table_result_t;

  class record_scoreboard;
    rec_t          held_q[$];
    table_result_t expected_q[$];
    int            errors;

    function new();
      errors = 0;
    endfunction

    // Apply one accepted request to the table copy and queue its result.
    function void note_request(logic req, logic signed [31:0] flow, logic [15:0] year);
      table_result_t r;
      rec_t          e;
      int            hit;
      int            pos;
      hit = -1;
      foreach (held_q[i]) if (hit < 0 && held_q[i].year == year) hit = i;
      if (req == REQ_INSERT) begin
        if (hit >= 0) begin
          r.status = STS_DUP_YEAR;
        end else if (held_q.size() >= DEPTH) begin
          r.status = STS_FULL;
        end else begin
          pos = 0;
          while (pos < held_q.size() && $signed(held_q[pos].flow) < $signed(flow)) pos++;
          e.year = year;
          e.flow = flow;
          held_q.insert(pos, e);
          r.status = STS_OK;
        end
      end else if (hit < 0) begin
        r.status = STS_NOT_FOUND;
      end else begin
        held_q.delete(hit);
        r.status = STS_OK;
      end
      r.count = 5'(held_q.size());
      if (held_q.size() > 0) begin
        r.head_valid = 1'b1;
        r.head_flow  = held_q[0].flow;
        r.head_year  = held_q[0].year;
      end else begin
        r.head_valid = 1'b0;
        r.head_flow  = '0;
        r.head_year  = '0;
      end
      expected_q.push_back(r);
    endfunction

    function void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [55:0] beat);
      table_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat expected none actual %h", $time, beat);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      field_check("status", 32'(exp_r.status), 32'(beat[1:0]));
      field_check("entry_count", 32'(exp_r.count), 32'(beat[6:2]));
      field_check("head_valid", 32'(exp_r.head_valid), 32'(beat[7]));
      field_check("head_flow", exp_r.head_flow, beat[39:8]);
      field_check("head_year", 32'(exp_r.head_year), 32'(beat[55:40]));
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  record_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_reqs      = 0;
  int holds_seen     = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  sorted_record_table #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: check each accepted beat, stall at random, hold off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (holds_seen != hold_reqs) begin
        holds_seen <= hold_reqs;
        hold_left  <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: count cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("sorted_record_table: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(logic req, logic [31:0] flow, logic [15:0] year);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {year, flow};
    do @(posedge clk); while (!in_tready);
    sb.note_request(req, flow, year);
  endtask

  // Stop offering and wait until every queued result has come back.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_request(bit grow);
    int          roll;
    int          n;
    logic        req;
    logic [31:0] flow;
    logic [15:0] year;
    n    = sb.held_q.size();
    roll = $urandom_range(99);
    case ($urandom_range(9))
      0:       flow = 32'h8000_0000;
      1:       flow = 32'h7FFF_FFFF;
      2:       flow = (n > 0) ? sb.held_q[$urandom_range(n - 1)].flow : $urandom;
      3:       flow = 32'($signed($urandom_range(8)) - 4) <<< 16;
      default: flow = $urandom;
    endcase
    year = ($urandom_range(3) == 0) ? 16'($urandom_range(31)) : 16'($urandom);
    if (!grow) roll = (roll < 25) ? roll : roll + 20;
    // Map the roll: new insert, duplicate insert, remove held, remove any.
    if (roll < 55) begin
      req = REQ_INSERT;
    end else if (roll < 65) begin
      req = REQ_INSERT;
      if (n > 0) year = sb.held_q[$urandom_range(n - 1)].year;
    end else if (roll < 110) begin
      req = REQ_REMOVE;
      if (n > 0) year = sb.held_q[$urandom_range(n - 1)].year;
    end else begin
      req = REQ_REMOVE;
    end
    send_item(req, flow, year);
  endtask

  int send_pcts[4] = '{0, 60, 0, 31};
  int recv_pcts[4] = '{0, 0, 60, 31};

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extremes, equal flows, duplicates, full table.
    send_item(REQ_REMOVE, 32'h0000_0000, 16'd5);
    send_item(REQ_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
    send_item(REQ_INSERT, 32'h8000_0000, 16'h0000);
    send_item(REQ_INSERT, 32'h8000_0000, 16'h0001);
    send_item(REQ_INSERT, 32'h8000_0000, 16'hFFFF);
    send_item(REQ_REMOVE, 32'hFFFF_FFFF, 16'h0001);
    send_item(REQ_REMOVE, 32'h0000_0000, 16'h0001);
    for (int i = 0; i < DEPTH - 2; i++) send_item(REQ_INSERT, $urandom, 16'(100 + i));
    send_item(REQ_INSERT, 32'h0000_0000, 16'h1234);
    send_item(REQ_INSERT, 32'h0000_0000, 16'hFFFF);
    send_item(REQ_REMOVE, 32'h0000_0000, 16'h0000);
    send_item(REQ_REMOVE, 32'h0000_0000, 16'hFFFF);
    wait_for_drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 0 && k == 40) hold_reqs <= hold_reqs + 1;
        if (p == 1 && k == 54) wait_for_drain();
        random_request(((k / 27) % 2) == 0);
      end
    end
    wait_for_drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("sorted_record_table: match");
    end else begin
      $display("sorted_record_table: mismatch");
    end
    $finish;
  end

endmodule

// File: sorted_record_table.f
hw/rtl/srt_pkg.sv
hw/rtl/sorted_record_table.sv
tb/sorted_record_table_test.sv
